/* sv/thq_pkg.sv */
// shared types, constants and pipeline control for the terrain height query block
package thq_pkg;

  // command and register codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 1'd1;

  // grid and scaling
  localparam int GRID_POINTS     = 256;
  localparam int TILE_SIZE       = 800;
  localparam int HEIGHT_SCALE    = 40;
  localparam int PIXEL_RANGE     = 256;
  localparam int COORD_FRAC_BITS = 8;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int IDX_W    = 8;
  localparam int SMP_W    = 8;
  localparam int HEIGHT_W = 15;

  // one cell spans DEN/(GRID_POINTS-1) in offset units
  localparam int DEN      = TILE_SIZE << COORD_FRAC_BITS;
  localparam int CELL_MUL = GRID_POINTS - 1;
  localparam int OFS_W    = $clog2(DEN);
  localparam int NUM_W    = 26;

  // DEN = 2^13 * 25: shift, then multiply by the reciprocal of 25
  localparam int CELL_PRE_SHIFT   = 13;
  localparam int CELL_RECIP       = 41944;
  localparam int CELL_RECIP_SHIFT = 20;
  localparam int CELL_RECIP_W     = 16;
  localparam int CELL_PROD_W      = NUM_W - CELL_PRE_SHIFT + CELL_RECIP_W;

  // height = round(d / HEIGHT_DIV), d = hnum - PIXEL_RANGE/2 * DEN
  localparam int HALF_RANGE_DEN = (PIXEL_RANGE / 2) * DEN;
  localparam int HEIGHT_DIV     = (PIXEL_RANGE * DEN) / (2 * HEIGHT_SCALE * 256);
  localparam int ROUND_BIAS     = HEIGHT_DIV / 2;
  localparam int D_W            = 26;
  localparam int WPROD_W        = 30;

  // HEIGHT_DIV = 2^9 * 5
  localparam int HDIV_PRE_SHIFT   = 9;
  localparam int HDIV_RECIP       = 52429;
  localparam int HDIV_RECIP_SHIFT = 18;
  localparam int HDIV_RECIP_W     = 16;
  localparam int HDIV_M_W         = D_W - HDIV_PRE_SHIFT;
  localparam int HDIV_PROD_W      = HDIV_M_W + HDIV_RECIP_W;
  localparam int Q_W              = 14;

  // sample store: four banks by row and column parity
  localparam int BANK_ADDR_W = 2 * (IDX_W - 1);
  localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;
  localparam int NUM_BANKS   = 4;

  localparam int NUM_STAGES = 9;
  localparam int MEM_STAGE  = 4;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [SMP_W-1:0] red;
  } sample_t;

  typedef struct packed {
    logic                is_query;
    logic                in_tile;
    sample_t             smp;
    logic [IDX_W-1:0]    gx;
    logic [IDX_W-1:0]    gz;
    logic [OFS_W-1:0]    rx;
    logic [OFS_W-1:0]    rz;
  } loc_t;

  typedef struct packed {
    logic [SMP_W-1:0] h00;
    logic [SMP_W-1:0] h10;
    logic [SMP_W-1:0] h01;
    logic [SMP_W-1:0] h11;
  } corners_t;

  typedef struct packed {
    logic [NUM_STAGES:1] load;
    logic                mem_wr;
  } pipe_ctrl_t;

endpackage

/* sv/thq_locate.sv */
// origin subtract, tile check and cell/fraction split by reciprocal multiply
module thq_locate import thq_pkg::*; (
  input  logic                      clk,
  input  pipe_ctrl_t                ctrl,
  input  logic                      cmd,
  input  logic [IDX_W-1:0]          sample_col,
  input  logic [IDX_W-1:0]          sample_row,
  input  logic [SMP_W-1:0]          red,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_z,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_z,
  output loc_t                      loc
);

  logic                    is_q1, is_q2, is_q3;
  sample_t                 smp1, smp2, smp3;
  logic [DIFF_W-1:0]       tx1, tz1;
  logic                    in2, in3;
  logic [NUM_W-1:0]        nx2, nz2, nx3, nz3;
  logic [CELL_PROD_W-1:0]  px3, pz3;
  logic [IDX_W-1:0]        gx, gz;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      is_q1 <= (cmd == CMD_QUERY);
      smp1  <= '{row: sample_row, col: sample_col, red: red};
      tx1   <= {query_x[COORD_W-1], query_x} - {origin_x[COORD_W-1], origin_x};
      tz1   <= {query_z[COORD_W-1], query_z} - {origin_z[COORD_W-1], origin_z};
    end
    if (ctrl.load[2]) begin
      is_q2 <= is_q1;
      smp2  <= smp1;
      // inside iff 0 <= t < DEN on both axes
      in2   <= !tx1[DIFF_W-1] && !tz1[DIFF_W-1] &&
               (tx1[DIFF_W-2:0] < (DIFF_W-1)'(DEN)) &&
               (tz1[DIFF_W-2:0] < (DIFF_W-1)'(DEN));
      nx2   <= NUM_W'(tx1[OFS_W-1:0]) * NUM_W'(CELL_MUL);
      nz2   <= NUM_W'(tz1[OFS_W-1:0]) * NUM_W'(CELL_MUL);
    end
    if (ctrl.load[3]) begin
      is_q3 <= is_q2;
      smp3  <= smp2;
      in3   <= in2;
      nx3   <= nx2;
      nz3   <= nz2;
      px3   <= CELL_PROD_W'(nx2[NUM_W-1:CELL_PRE_SHIFT]) * CELL_PROD_W'(CELL_RECIP);
      pz3   <= CELL_PROD_W'(nz2[NUM_W-1:CELL_PRE_SHIFT]) * CELL_PROD_W'(CELL_RECIP);
    end
  end

  assign gx = px3[CELL_RECIP_SHIFT +: IDX_W];
  assign gz = pz3[CELL_RECIP_SHIFT +: IDX_W];

  always_comb begin
    loc.is_query = is_q3;
    loc.in_tile  = in3;
    loc.smp      = smp3;
    loc.gx       = gx;
    loc.gz       = gz;
    loc.rx       = OFS_W'(nx3 - NUM_W'(gx) * NUM_W'(DEN));
    loc.rz       = OFS_W'(nz3 - NUM_W'(gz) * NUM_W'(DEN));
  end

endmodule

/* sv/thq_sample_mem.sv */
// four parity banks of height samples, one write or four corner reads per cycle
module thq_sample_mem import thq_pkg::*; (
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  loc_t       loc,
  output corners_t   corners
);

  logic [SMP_W-1:0] rd_data [NUM_BANKS];
  logic             gx0, gz0;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic [1:0] BANK_SEL = 2'(b);
    localparam logic CP = BANK_SEL[0];
    localparam logic RP = BANK_SEL[1];

    logic [SMP_W-1:0]       mem [BANK_DEPTH];
    logic [IDX_W-1:0]       rd_col, rd_row;
    logic [BANK_ADDR_W-1:0] rd_addr, wr_addr;
    logic                   wr_hit;

    // the corner of this bank is gx or gx+1, whichever has the bank's parity
    assign rd_col  = loc.gx + IDX_W'(CP ^ loc.gx[0]);
    assign rd_row  = loc.gz + IDX_W'(RP ^ loc.gz[0]);
    assign rd_addr = {rd_row[IDX_W-1:1], rd_col[IDX_W-1:1]};
    assign wr_addr = {loc.smp.row[IDX_W-1:1], loc.smp.col[IDX_W-1:1]};
    assign wr_hit  = (loc.smp.row[0] == RP) && (loc.smp.col[0] == CP);

    always_ff @(posedge clk) begin
      if (ctrl.mem_wr && wr_hit) begin
        mem[wr_addr] <= loc.smp.red;
      end
      if (ctrl.load[MEM_STAGE]) begin
        rd_data[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[MEM_STAGE]) begin
      gx0 <= loc.gx[0];
      gz0 <= loc.gz[0];
    end
  end

  always_comb begin
    corners.h00 = rd_data[{gz0, gx0}];
    corners.h10 = rd_data[{gz0, ~gx0}];
    corners.h01 = rd_data[{~gz0, gx0}];
    corners.h11 = rd_data[{~gz0, ~gx0}];
  end

endmodule

/* sv/thq_interp.sv */
// triangle pick, barycentric weighting and rounded height scaling
module thq_interp import thq_pkg::*; (
  input  logic                       clk,
  input  pipe_ctrl_t                 ctrl,
  input  loc_t                       loc,
  input  corners_t                   corners,
  output logic signed [HEIGHT_W-1:0] height,
  output logic                       in_tile
);

  logic [OFS_W-1:0]          rx4, rz4, rx5, rz5;
  logic                      in4, in5, in6, in7, in8;
  logic                      lower;
  logic signed [SMP_W+1:0]   a5;
  logic signed [SMP_W:0]     b5, c5;
  logic signed [WPROD_W-1:0] ta6, tb6, tc6;
  logic signed [D_W-1:0]     d7;
  logic [D_W-2:0]            mag;
  logic [D_W-1:0]            biased;
  logic                      neg8;
  logic [HDIV_PROD_W-1:0]    p8;
  logic [Q_W-1:0]            q;

  assign lower = ({1'b0, rx4} + {1'b0, rz4}) <= (OFS_W+1)'(DEN);

  assign mag    = d7[D_W-1] ? (D_W-1)'(-d7) : (D_W-1)'(d7);
  assign biased = D_W'(mag) + D_W'(ROUND_BIAS);
  assign q      = p8[HDIV_RECIP_SHIFT +: Q_W];

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      rx4 <= loc.rx;
      rz4 <= loc.rz;
      in4 <= loc.in_tile;
    end
    if (ctrl.load[5]) begin
      rx5 <= rx4;
      rz5 <= rz4;
      in5 <= in4;
      if (lower) begin
        a5 <= $signed((SMP_W+2)'(corners.h00));
        b5 <= $signed((SMP_W+1)'(corners.h10) - (SMP_W+1)'(corners.h00));
        c5 <= $signed((SMP_W+1)'(corners.h01) - (SMP_W+1)'(corners.h00));
      end else begin
        a5 <= $signed((SMP_W+2)'(corners.h10) + (SMP_W+2)'(corners.h01)
                      - (SMP_W+2)'(corners.h11));
        b5 <= $signed((SMP_W+1)'(corners.h11) - (SMP_W+1)'(corners.h01));
        c5 <= $signed((SMP_W+1)'(corners.h11) - (SMP_W+1)'(corners.h10));
      end
    end
    if (ctrl.load[6]) begin
      in6 <= in5;
      ta6 <= WPROD_W'(a5) * $signed(WPROD_W'(DEN));
      tb6 <= WPROD_W'(b5) * $signed(WPROD_W'(rx5));
      tc6 <= WPROD_W'(c5) * $signed(WPROD_W'(rz5));
    end
    if (ctrl.load[7]) begin
      in7 <= in6;
      d7  <= D_W'(ta6 + tb6 + tc6 - $signed(WPROD_W'(HALF_RANGE_DEN)));
    end
    if (ctrl.load[8]) begin
      in8  <= in7;
      neg8 <= d7[D_W-1];
      p8   <= HDIV_PROD_W'(biased[D_W-1:HDIV_PRE_SHIFT]) * HDIV_PROD_W'(HDIV_RECIP);
    end
    if (ctrl.load[9]) begin
      in_tile <= in8;
      if (!in8) begin
        height <= '0;
      end else if (neg8) begin
        height <= -$signed(HEIGHT_W'(q));
      end else begin
        height <= $signed(HEIGHT_W'(q));
      end
    end
  end

endmodule

/* sv/terrain_height_query.sv */
// terrain_height_query: heightmap store with barycentric height lookup.
// Takes one transaction per cycle, loads and queries alike, through nine pipeline
// stages, and only a held-off out_ready stalls the flow. A load (cmd 0) writes its
// sample at the memory stage and returns nothing; a query (cmd 1) reads the four
// cell corners in the same stage from four banks split by row and column parity,
// so loads and queries keep their order without forwarding. Points outside the
// grid return height 0 with in_tile clear. The origin registers are written
// through the cfg port (index 0 for x, 1 for z); the user must write them only
// while the block is idle, which the block itself does not enforce. Samples read
// before being loaded are undefined.
module terrain_height_query import thq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [IDX_W-1:0]           sample_col,
  input  logic [IDX_W-1:0]           sample_row,
  input  logic [SMP_W-1:0]           red,
  input  logic signed [COORD_W-1:0]  query_x,
  input  logic signed [COORD_W-1:0]  query_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [HEIGHT_W-1:0] height,
  output logic                       in_tile
);

  logic signed [COORD_W-1:0] origin_x, origin_z;
  logic [NUM_STAGES:1]       valid;
  pipe_ctrl_t                ctrl;
  loc_t                      loc;
  corners_t                  corners;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= $signed(cfg_data);
        REG_ORIGIN_Z: origin_z <= $signed(cfg_data);
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ctrl.load[NUM_STAGES] = !valid[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      ctrl.load[k] = !valid[k] || ctrl.load[k+1];
    end
    ctrl.mem_wr = ctrl.load[MEM_STAGE] && valid[MEM_STAGE-1] && !loc.is_query;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (ctrl.load[k]) begin
          if (k == 1) begin
            valid[k] <= in_valid;
          end else if (k == MEM_STAGE) begin
            // loads retire at the memory stage
            valid[k] <= valid[k-1] && loc.is_query;
          end else begin
            valid[k] <= valid[k-1];
          end
        end
      end
    end
  end

  assign in_ready  = ctrl.load[1];
  assign out_valid = valid[NUM_STAGES];

  thq_locate u_locate (
    .clk        (clk),
    .ctrl       (ctrl),
    .cmd        (cmd),
    .sample_col (sample_col),
    .sample_row (sample_row),
    .red        (red),
    .query_x    (query_x),
    .query_z    (query_z),
    .origin_x   (origin_x),
    .origin_z   (origin_z),
    .loc        (loc)
  );

  thq_sample_mem u_mem (
    .clk     (clk),
    .ctrl    (ctrl),
    .loc     (loc),
    .corners (corners)
  );

  thq_interp u_interp (
    .clk     (clk),
    .ctrl    (ctrl),
    .loc     (loc),
    .corners (corners),
    .height  (height),
    .in_tile (in_tile)
  );

`ifndef ASSERT_OFF
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_tile |-> height == '0)
    else $error("outside point with nonzero height");

  a_height_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_tile |-> (height <= HEIGHT_W'(10240)) && (height >= -HEIGHT_W'(10240)))
    else $error("height outside scaled range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_no_wr_on_query: assert property (@(posedge clk) disable iff (rst)
    ctrl.mem_wr |-> !valid[MEM_STAGE-1] || !loc.is_query)
    else $error("sample write issued for a query");
`endif

endmodule

/* verif/testbench.sv */
// self-checking testbench for terrain_height_query: sample loads, height queries, origin registers
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import thq_pkg::*;

  localparam int SIDE         = 1 << IDX_W;
  localparam int LAST_CELL    = GRID_POINTS - 2;
  localparam int HEIGHT_FRAC  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = NUM_STAGES + 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 50;
  localparam longint HEIGHT_LO = -(longint'(1) << (HEIGHT_W - 1));
  localparam longint HEIGHT_HI = (longint'(1) << (HEIGHT_W - 1)) - 1;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic                       in_tile;
  } height_result_t;

  // mirror of the sample store and origins, plus the queue of predicted heights
  class terrain_height_tracker;
    logic [SMP_W-1:0] samples [0:SIDE*SIDE-1];
    longint           org_x;
    longint           org_z;
    height_result_t   expected_heights[$];
    int               errors;

    function void set_origin(logic [CFG_IDX_W-1:0] idx, logic signed [COORD_W-1:0] value);
      case (idx)
        REG_ORIGIN_X: org_x = value;
        REG_ORIGIN_Z: org_z = value;
        default: ;
      endcase
    endfunction

    // cell and remainders of a world point; returns 1 when the point is on the grid
    function bit locate(input logic signed [COORD_W-1:0] qx, qz,
                        output int gx, gz, output longint rx, rz);
      longint tx, tz;
      tx = longint'(qx) - org_x;
      tz = longint'(qz) - org_z;
      gx = 0;
      gz = 0;
      rx = 0;
      rz = 0;
      if (tx < 0 || tz < 0) return 1'b0;
      gx = int'(tx * CELL_MUL / DEN);
      gz = int'(tz * CELL_MUL / DEN);
      rx = tx * CELL_MUL % DEN;
      rz = tz * CELL_MUL % DEN;
      return (gx < CELL_MUL) && (gz < CELL_MUL);
    endfunction

    function void note_transaction(logic c, logic [IDX_W-1:0] col, row, logic [SMP_W-1:0] r,
                                   logic signed [COORD_W-1:0] qx, qz);
      height_result_t res;
      int gx, gz;
      longint rx, rz, h00, h10, h01, h11, hnum, num, dd, mag, q;
      if (c == CMD_LOAD) begin
        samples[{row, col}] = r;
        return;
      end
      res.height = '0;
      res.in_tile = 1'b0;
      if (locate(qx, qz, gx, gz, rx, rz)) begin
        h00 = samples[gz * SIDE + gx];
        h10 = samples[gz * SIDE + gx + 1];
        h01 = samples[(gz + 1) * SIDE + gx];
        h11 = samples[(gz + 1) * SIDE + gx + 1];
        // lower triangle when the two fractions sum to at most one cell
        if (rx + rz <= DEN) begin
          hnum = h00 * DEN + (h10 - h00) * rx + (h01 - h00) * rz;
        end else begin
          hnum = (h10 + h01 - h11) * DEN + (h11 - h01) * rx + (h11 - h10) * rz;
        end
        num = (2 * hnum - longint'(PIXEL_RANGE) * DEN) * HEIGHT_SCALE
              * (longint'(1) << HEIGHT_FRAC);
        dd = longint'(PIXEL_RANGE) * DEN;
        mag = (num < 0) ? -num : num;
        // round half away from zero
        q = (mag + dd / 2) / dd;
        if (num < 0) q = -q;
        if (q < HEIGHT_LO) q = HEIGHT_LO;
        if (q > HEIGHT_HI) q = HEIGHT_HI;
        res.height = q[HEIGHT_W-1:0];
        res.in_tile = 1'b1;
      end
      expected_heights.push_back(res);
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_height(logic signed [HEIGHT_W-1:0] got_h, logic got_in_tile);
      height_result_t want;
      if (expected_heights.size() == 0) begin
        report($sformatf("result with nothing pending: height %0d in_tile %b",
                         got_h, got_in_tile));
        return;
      end
      want = expected_heights.pop_front();
      if (got_h !== want.height)
        report($sformatf("height %0d, predicted %0d", got_h, want.height));
      if (got_in_tile !== want.in_tile)
        report($sformatf("in_tile %b, predicted %b", got_in_tile, want.in_tile));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COORD_W-1:0]         cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       cmd;
  logic [IDX_W-1:0]           sample_col;
  logic [IDX_W-1:0]           sample_row;
  logic [SMP_W-1:0]           red;
  logic signed [COORD_W-1:0]  query_x;
  logic signed [COORD_W-1:0]  query_z;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [HEIGHT_W-1:0] height;
  logic                       in_tile;

  terrain_height_tracker tracker = new;

  // stimulus-side bookkeeping: which samples are loaded and which cells may be queried
  bit smp_written [0:SIDE*SIDE-1];
  bit cell_ok [0:SIDE*SIDE-1];
  int ready_cells[$];
  int items_sent;
  bit idling_on = 1'b1;
  bit hold_armed;
  int cycle_count;

  terrain_height_query uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .sample_col (sample_col),
    .sample_row (sample_row),
    .red        (red),
    .query_x    (query_x),
    .query_z    (query_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .height     (height),
    .in_tile    (in_tile)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint cell_start(int k);
    return (longint'(k) * DEN + CELL_MUL - 1) / CELL_MUL;
  endfunction

  function automatic longint pick_in_cell(int k);
    longint lo, hi;
    lo = cell_start(k);
    hi = cell_start(k + 1) - 1;
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return lo + $urandom_range(0, int'(hi - lo));
    endcase
  endfunction

  // offsets at the grid border and at cell boundaries
  function automatic longint edge_offset();
    case ($urandom_range(0, 5))
      0: return -1;
      1: return 0;
      2: return cell_start(LAST_CELL + 1) - 1;
      3: return cell_start(LAST_CELL + 1);
      4: return cell_start($urandom_range(1, LAST_CELL));
      default: return cell_start($urandom_range(1, LAST_CELL)) - 1;
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] random_red();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return SMP_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_origin();
    logic signed [COORD_W-1:0] v;
    v = $urandom;
    return v >>> 1;
  endfunction

  task automatic drive_item(logic c, logic [IDX_W-1:0] col, row, logic [SMP_W-1:0] r,
                            logic signed [COORD_W-1:0] qx, qz);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    sample_col <= col;
    sample_row <= row;
    red        <= r;
    query_x    <= qx;
    query_z    <= qz;
    do @(posedge clk); while (!in_ready);
    tracker.note_transaction(c, col, row, r, qx, qz);
    items_sent++;
  endtask

  task automatic send_load(int col, int row, logic [SMP_W-1:0] r);
    int cx, cz, k;
    smp_written[row * SIDE + col] = 1'b1;
    // a cell becomes queryable once all four corners are loaded
    for (k = 0; k < 4; k++) begin
      cx = col - k[0];
      cz = row - k[1];
      if (cx >= 0 && cz >= 0 && cx <= LAST_CELL && cz <= LAST_CELL && !cell_ok[cz*SIDE+cx]
          && smp_written[cz*SIDE+cx] && smp_written[cz*SIDE+cx+1]
          && smp_written[(cz+1)*SIDE+cx] && smp_written[(cz+1)*SIDE+cx+1]) begin
        cell_ok[cz*SIDE+cx] = 1'b1;
        ready_cells.push_back(cz * SIDE + cx);
      end
    end
    drive_item(CMD_LOAD, IDX_W'(col), IDX_W'(row), r, $urandom, $urandom);
  endtask

  // points that would read a cell with unloaded corners are redrawn
  task automatic send_query(logic signed [COORD_W-1:0] qx, qz);
    int gx, gz;
    longint rx, rz;
    while (tracker.locate(qx, qz, gx, gz, rx, rz) && !cell_ok[gz * SIDE + gx]) begin
      qx = $urandom;
      qz = $urandom;
    end
    drive_item(CMD_QUERY, IDX_W'($urandom), IDX_W'($urandom), SMP_W'($urandom), qx, qz);
  endtask

  task automatic query_in_cell(int gx, int gz);
    send_query(32'(tracker.org_x + pick_in_cell(gx)), 32'(tracker.org_z + pick_in_cell(gz)));
  endtask

  task automatic random_step();
    int pick, gx, gz, n, k, tmp, cell_idx;
    int corner_order[4];
    pick = $urandom_range(0, 99);
    if (pick < 30 || ready_cells.size() == 0) begin
      // load a whole cell in random corner order, then look inside it
      gx = $urandom_range(0, LAST_CELL);
      gz = $urandom_range(0, LAST_CELL);
      if ($urandom_range(0, 9) == 0) gx = $urandom_range(0, 1) ? LAST_CELL : 0;
      if ($urandom_range(0, 9) == 0) gz = $urandom_range(0, 1) ? LAST_CELL : 0;
      corner_order = '{0, 1, 2, 3};
      for (k = 3; k > 0; k--) begin
        n = $urandom_range(0, k);
        tmp = corner_order[k];
        corner_order[k] = corner_order[n];
        corner_order[n] = tmp;
      end
      for (k = 0; k < 4; k++)
        send_load(gx + corner_order[k][0], gz + corner_order[k][1], random_red());
      repeat ($urandom_range(1, 3)) query_in_cell(gx, gz);
    end else if (pick < 65) begin
      cell_idx = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
      query_in_cell(cell_idx % SIDE, cell_idx / SIDE);
    end else if (pick < 80) begin
      send_query(32'(tracker.org_x + edge_offset()), 32'(tracker.org_z + edge_offset()));
    end else if (pick < 90) begin
      send_load($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1), random_red());
    end else begin
      send_query($urandom, $urandom);
    end
  endtask

  task automatic run_random(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_step();
  endtask

  task automatic set_origins(logic signed [COORD_W-1:0] ox, oz);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= ox;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_origin(REG_ORIGIN_X, ox);
    cfg_index <= REG_ORIGIN_Z;
    cfg_data  <= oz;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_origin(REG_ORIGIN_Z, oz);
    cfg_valid <= 1'b0;
  endtask

  // wait until every query is answered and trailing loads have drained
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tracker.check_height(height, in_tile);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ORIGIN_X;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    cmd        <= CMD_LOAD;
    sample_col <= '0;
    sample_row <= '0;
    red        <= '0;
    query_x    <= '0;
    query_z    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_origins('0, '0);
    // corner cells of the grid, and a cell where the triangle diagonal is hit exactly
    send_load(0, 0, 8'd0);
    send_load(1, 0, 8'd255);
    send_load(0, 1, 8'd128);
    send_load(1, 1, 8'd255);
    send_load(254, 254, 8'd255);
    send_load(255, 254, 8'd0);
    send_load(254, 255, 8'd1);
    send_load(255, 255, 8'd254);
    send_load(50, 0, 8'd10);
    send_load(51, 0, 8'd200);
    send_load(50, 1, 8'd77);
    send_load(51, 1, 8'd240);
    send_query(0, 0);
    send_query(803, 0);
    // x cell 50 with z cell 0: fractions sum to exactly one, then just past it
    send_query(40157, 803);
    send_query(40158, 803);
    send_query(204799, 204799);
    send_query(204800, 0);
    send_query(-1, 5);
    send_query(COORD_MIN, COORD_MAX);
    send_query(COORD_MAX, COORD_MIN);
    run_random(300);

    settle();
    set_origins(COORD_MIN, COORD_MAX);
    run_random(100);

    settle();
    set_origins(COORD_MAX - DEN, COORD_MIN);
    run_random(300);

    // receiver holds off while loads and queries keep coming
    settle();
    set_origins(rand_origin(), rand_origin());
    hold_armed = 1'b1;
    run_random(350);

    settle();
    idling_on = 1'b0;
    set_origins(rand_origin(), rand_origin());
    run_random(400);

    settle();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
